// ===== sv/qrs_pkg.sv =====
// Shared constants and types for the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
   localparam int QRS_FRAC_BITS = 16;
   localparam int QRS_COEF_W    = 32;

   typedef enum logic [2:0] {
      KIND_LINEAR = 3'd0,
      KIND_NO_B   = 3'd1,
      KIND_NO_C   = 3'd2,
      KIND_FULL   = 3'd3,
      KIND_NONE   = 3'd4
   } kind_type;
endpackage
`default_nettype wire

// ===== sv/quadratic_root_solver_core.sv =====
// Quadratic root solver top level: classify, discriminant root, divide, saturate, root.
//
//   channel | dir | tdata (low bit up)                     | tuser (low bit up)
//   req_    | in  | coef_a, coef_b, coef_c                  | -
//   rsp_    | out | answer, root_low, root_high             | answer_valid, case_kind, saturated
//
// One beat in per cycle while the output skid is empty. The pipe holds the
// discriminant root (33 stages), the divider (34 + FRAC_BITS stages) and
// the second root (31 stages). Reset clears all valid bits and the output skid.
// The whole pipe holds while the skid beat waits; req_tready is the inverse of the skid-full register.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver_core
   import qrs_pkg::*;
#(
   parameter int FRAC_BITS = QRS_FRAC_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // coef_a, coef_b, coef_c
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // answer, root_low, root_high
   output logic [4:0]       rsp_tuser    // answer_valid, case_kind, saturated
);
   localparam int NUM_W  = FRAC_BITS + 34;
   localparam int NUM_SW = NUM_W + 1;
   localparam int DEN_W  = QRS_COEF_W + 1;
   localparam int SQA_W  = 2 * QRS_COEF_W + 2;
   localparam int SQA_R  = SQA_W / 2;
   localparam int SQB_W  = 62;
   localparam int SQB_R  = SQB_W / 2;
   localparam int BIG_SH = 62 - FRAC_BITS;
   localparam bit BIG_OK = (BIG_SH < NUM_W);

   localparam logic signed [31:0] NEG_ONE = -(32'sd1 <<< FRAC_BITS);
   localparam logic signed [31:0] MAX32   = 32'sh7fffffff;
   localparam logic signed [NUM_SW-1:0] MAXW = NUM_SW'(MAX32);
   localparam logic signed [NUM_SW-1:0] MINW = NUM_SW'(signed'(32'h80000000));
   localparam logic signed [NUM_SW-1:0] BIGW = NUM_SW'(1) <<< (BIG_OK ? BIG_SH : 0);

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      kind_type           kind;
      logic               ok;
   } front_type;

   typedef struct packed {
      kind_type kind;
      logic     ok;
      logic     neg_a;
      logic     neg_b;
   } dside_type;

   typedef struct packed {
      kind_type           kind;
      logic               valid;
      logic               use_root;
      logic signed [31:0] ans;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic               clip;
   } back_type;

   typedef struct packed {
      logic               clip;
      kind_type           kind;
      logic               valid;
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      logic signed [31:0] ans;
   } res_type;

   logic en;
   logic skid_full_ff;
   assign en         = !skid_full_ff;
   assign req_tready = en;

   // stage 0: input capture
   logic               v0_ff;
   logic signed [31:0] a0_ff, b0_ff, c0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (en) v0_ff <= req_tvalid;
      if (en) begin
         a0_ff <= req_tdata[31:0];
         b0_ff <= req_tdata[63:32];
         c0_ff <= req_tdata[95:64];
      end
   end

   // stage 1: products and case
   logic               v1_ff;
   logic signed [63:0] bb1_ff, ac1_ff;
   front_type          f1_ff, f1_in;
   always_comb begin
      f1_in.a  = a0_ff;
      f1_in.b  = b0_ff;
      f1_in.c  = c0_ff;
      f1_in.ok = 1'b1;
      if (a0_ff == 0) begin
         f1_in.kind = (b0_ff != 0) ? KIND_LINEAR : KIND_NONE;
      end else if (b0_ff == 0) begin
         f1_in.kind = KIND_NO_B;
         f1_in.ok   = (c0_ff == 0) || (c0_ff[31] != a0_ff[31]);
      end else if (c0_ff == 0) begin
         f1_in.kind = KIND_NO_C;
      end else begin
         f1_in.kind = KIND_FULL;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= v0_ff;
      if (en) begin
         bb1_ff <= b0_ff * b0_ff;
         ac1_ff <= a0_ff * c0_ff;
         f1_ff  <= f1_in;
      end
   end

   // stage 2: discriminant b*b - 4ac, exact
   logic             v2_ff;
   logic [SQA_W-1:0] op2_ff, disc;
   front_type        f2_ff, f2_in;
   always_comb begin
      disc  = {{2{bb1_ff[63]}}, bb1_ff} - {ac1_ff, 2'b00};
      f2_in = f1_ff;
      if (f1_ff.kind == KIND_FULL) f2_in.ok = !disc[SQA_W-1];
   end
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
      if (en) begin
         op2_ff <= disc[SQA_W-1] ? '0 : disc;
         f2_ff  <= f2_in;
      end
   end

   logic             sa_v;
   logic [SQA_R-1:0] sa_root;
   front_type        sa_side;
   qrs_sqrt #(.OP_W(SQA_W), .SIDE_W($bits(front_type))) u_sqrt_disc (
      .clock, .reset, .en,
      .in_valid(v2_ff), .in_op(op2_ff), .in_side(f2_ff),
      .out_valid(sa_v), .out_root(sa_root), .out_side(sa_side)
   );

   // stage 3: signed numerators and divisor
   logic                      v3_ff;
   logic signed [NUM_SW-1:0]  n1_3_ff, n2_3_ff, n1_in, n2_in;
   logic signed [DEN_W:0]     d3_ff, d_in;
   dside_type                 s3_ff;
   always_comb begin
      logic signed [NUM_SW-1:0] bx, cx, sx;
      bx    = NUM_SW'(sa_side.b);
      cx    = NUM_SW'(sa_side.c);
      sx    = signed'(NUM_SW'(sa_root));
      n1_in = '0;
      n2_in = '0;
      d_in  = '0;
      case (sa_side.kind)
         KIND_LINEAR: begin
            n1_in = (-cx) <<< FRAC_BITS;
            d_in  = (DEN_W+1)'(sa_side.b);
         end
         KIND_NO_B: begin
            n1_in = (-cx) <<< FRAC_BITS;
            d_in  = (DEN_W+1)'(sa_side.a);
         end
         KIND_NO_C: begin
            n1_in = (-bx) <<< FRAC_BITS;
            d_in  = (DEN_W+1)'(sa_side.a);
         end
         KIND_FULL: begin
            n1_in = (sx - bx) <<< FRAC_BITS;
            n2_in = (-bx - sx) <<< FRAC_BITS;
            d_in  = (DEN_W+1)'(sa_side.a) <<< 1;
         end
         default: begin
            n1_in = '0;
         end
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= sa_v;
      if (en) begin
         n1_3_ff     <= n1_in;
         n2_3_ff     <= n2_in;
         d3_ff       <= d_in;
         s3_ff.kind  <= sa_side.kind;
         s3_ff.ok    <= sa_side.ok;
         s3_ff.neg_a <= 1'b0;
         s3_ff.neg_b <= 1'b0;
      end
   end

   // stage 4: magnitudes and quotient signs
   logic              v4_ff;
   logic [NUM_W-1:0]  m1_ff, m2_ff;
   logic [DEN_W-1:0]  dm_ff;
   dside_type         s4_ff;
   logic [NUM_SW-1:0] m1_w, m2_w;
   logic [DEN_W:0]    dm_w;
   assign m1_w = n1_3_ff[NUM_SW-1] ? -n1_3_ff : n1_3_ff;
   assign m2_w = n2_3_ff[NUM_SW-1] ? -n2_3_ff : n2_3_ff;
   assign dm_w = d3_ff[DEN_W] ? -d3_ff : d3_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
      if (en) begin
         m1_ff       <= m1_w[NUM_W-1:0];
         m2_ff       <= m2_w[NUM_W-1:0];
         dm_ff       <= dm_w[DEN_W-1:0];
         s4_ff.kind  <= s3_ff.kind;
         s4_ff.ok    <= s3_ff.ok;
         s4_ff.neg_a <= n1_3_ff[NUM_SW-1] ^ d3_ff[DEN_W];
         s4_ff.neg_b <= n2_3_ff[NUM_SW-1] ^ d3_ff[DEN_W];
      end
   end

   logic             dv_v;
   logic [NUM_W-1:0] dv_qa, dv_qb;
   dside_type        dv_side;
   qrs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W($bits(dside_type))) u_div (
      .clock, .reset, .en,
      .in_valid(v4_ff), .in_num_a(m1_ff), .in_num_b(m2_ff), .in_den(dm_ff),
      .in_side(s4_ff),
      .out_valid(dv_v), .out_quo_a(dv_qa), .out_quo_b(dv_qb), .out_side(dv_side)
   );

   // stage 5: restore quotient sign (truncation toward zero)
   logic                     v5_ff;
   logic signed [NUM_SW-1:0] q1_ff, q2_ff, qa_w, qb_w;
   dside_type                s5_ff;
   assign qa_w = signed'({1'b0, dv_qa});
   assign qb_w = signed'({1'b0, dv_qb});
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (en) v5_ff <= dv_v;
      if (en) begin
         q1_ff <= dv_side.neg_a ? -qa_w : qa_w;
         q2_ff <= dv_side.neg_b ? -qb_w : qb_w;
         s5_ff <= dv_side;
      end
   end

   // stage 6: saturation, root operand
   logic               v6_ff;
   logic signed [31:0] r1_ff, r2_ff;
   logic               c1_ff, c2_ff, big6_ff;
   logic [SQB_W-1:0]   sq6_ff;
   dside_type          s6_ff;
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (en) v6_ff <= v5_ff;
      if (en) begin
         if (q1_ff > MAXW) begin
            r1_ff <= MAX32;
            c1_ff <= 1'b1;
         end else if (q1_ff < MINW) begin
            r1_ff <= signed'(32'h80000000);
            c1_ff <= 1'b1;
         end else begin
            r1_ff <= q1_ff[31:0];
            c1_ff <= 1'b0;
         end
         if (q2_ff > MAXW) begin
            r2_ff <= MAX32;
            c2_ff <= 1'b1;
         end else if (q2_ff < MINW) begin
            r2_ff <= signed'(32'h80000000);
            c2_ff <= 1'b1;
         end else begin
            r2_ff <= q2_ff[31:0];
            c2_ff <= 1'b0;
         end
         big6_ff <= BIG_OK && (q1_ff >= BIGW);
         sq6_ff  <= SQB_W'(q1_ff[NUM_W-1:0]) << FRAC_BITS;
         s6_ff   <= s5_ff;
      end
   end

   // stage 7: order roots, pick per-case outputs
   logic             v7_ff;
   logic [SQB_W-1:0] sq7_ff;
   back_type         b7_ff, b7_in;
   always_comb begin
      logic signed [31:0] lo, hi;
      lo = (r1_ff < r2_ff) ? r1_ff : r2_ff;
      hi = (r1_ff < r2_ff) ? r2_ff : r1_ff;
      b7_in.kind     = s6_ff.kind;
      b7_in.valid    = 1'b0;
      b7_in.use_root = 1'b0;
      b7_in.ans      = NEG_ONE;
      b7_in.lo       = '0;
      b7_in.hi       = '0;
      b7_in.clip     = 1'b0;
      case (s6_ff.kind)
         KIND_LINEAR, KIND_NO_C: begin
            b7_in.valid = 1'b1;
            b7_in.ans   = r1_ff;
            b7_in.clip  = c1_ff;
         end
         KIND_NO_B: begin
            if (s6_ff.ok) begin
               b7_in.valid    = 1'b1;
               b7_in.use_root = !big6_ff;
               b7_in.ans      = MAX32;
               b7_in.clip     = big6_ff;
            end
         end
         KIND_FULL: begin
            if (s6_ff.ok) begin
               b7_in.valid = 1'b1;
               b7_in.ans   = hi;
               b7_in.lo    = lo;
               b7_in.hi    = hi;
               b7_in.clip  = c1_ff | c2_ff;
            end
         end
         default: begin
            b7_in.valid = 1'b0;
         end
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (en) v7_ff <= v6_ff;
      if (en) begin
         sq7_ff <= sq6_ff;
         b7_ff  <= b7_in;
      end
   end

   logic             sb_v;
   logic [SQB_R-1:0] sb_root;
   back_type         sb_side;
   qrs_sqrt #(.OP_W(SQB_W), .SIDE_W($bits(back_type))) u_sqrt_quo (
      .clock, .reset, .en,
      .in_valid(v7_ff), .in_op(sq7_ff), .in_side(b7_ff),
      .out_valid(sb_v), .out_root(sb_root), .out_side(sb_side)
   );

   // final beat, then output register with a one-beat skid
   res_type pipe_res;
   always_comb begin
      pipe_res.ans   = sb_side.use_root ? signed'(32'(sb_root)) : sb_side.ans;
      pipe_res.lo    = sb_side.lo;
      pipe_res.hi    = sb_side.hi;
      pipe_res.valid = sb_side.valid;
      pipe_res.kind  = sb_side.kind;
      pipe_res.clip  = sb_side.clip;
   end

   logic    out_v_ff;
   res_type out_ff, skid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff     <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_tready) skid_full_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         out_v_ff <= sb_v;
      end else if (sb_v) begin
         skid_full_ff <= 1'b1;
      end
      if (skid_full_ff) begin
         if (rsp_tready) out_ff <= skid_ff;
      end else if (!out_v_ff || rsp_tready) begin
         out_ff <= pipe_res;
      end else if (sb_v) begin
         skid_ff <= pipe_res;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_ff.hi, out_ff.lo, out_ff.ans};
   assign rsp_tuser  = {out_ff.clip, out_ff.kind, out_ff.valid};
endmodule
`default_nettype wire

// ===== sv/qrs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two numerators over one divisor.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div
   import qrs_pkg::*;
#(
   parameter int NUM_W  = QRS_FRAC_BITS + 34,
   parameter int DEN_W  = QRS_COEF_W + 1,
   parameter int SIDE_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num_a,
   input  wire logic [NUM_W-1:0]  in_num_b,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [NUM_W-1:0]       out_quo_a,
   output logic [NUM_W-1:0]       out_quo_b,
   output logic [SIDE_W-1:0]      out_side
);
   logic [NUM_W-1:0]  vld_ff;
   logic [DEN_W-1:0]  rem_a_ff [NUM_W];
   logic [DEN_W-1:0]  rem_a_in [NUM_W];
   logic [DEN_W-1:0]  rem_b_ff [NUM_W];
   logic [DEN_W-1:0]  rem_b_in [NUM_W];
   logic [NUM_W-1:0]  na_ff    [NUM_W];
   logic [NUM_W-1:0]  na_in    [NUM_W];
   logic [NUM_W-1:0]  nb_ff    [NUM_W];
   logic [NUM_W-1:0]  nb_in    [NUM_W];
   logic [DEN_W-1:0]  den_ff   [NUM_W];
   logic [DEN_W-1:0]  den_in   [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];
   logic [SIDE_W-1:0] side_in  [NUM_W];

   // numerator register shifts left; quotient bits fill in from the bottom
   always_comb begin
      logic [DEN_W-1:0]  ra, rb, dn;
      logic [NUM_W-1:0]  xa, xb;
      logic [SIDE_W-1:0] sd;
      logic [DEN_W:0]    ta, tb, da, db;
      for (int k = 0; k < NUM_W; k++) begin
         if (k == 0) begin
            ra = '0;
            rb = '0;
            xa = in_num_a;
            xb = in_num_b;
            dn = in_den;
            sd = in_side;
         end else begin
            ra = rem_a_ff[k-1];
            rb = rem_b_ff[k-1];
            xa = na_ff[k-1];
            xb = nb_ff[k-1];
            dn = den_ff[k-1];
            sd = side_ff[k-1];
         end
         ta = {ra, xa[NUM_W-1]};
         tb = {rb, xb[NUM_W-1]};
         da = ta - {1'b0, dn};
         db = tb - {1'b0, dn};
         if (ta >= {1'b0, dn}) begin
            rem_a_in[k] = da[DEN_W-1:0];
            na_in[k]    = {xa[NUM_W-2:0], 1'b1};
         end else begin
            rem_a_in[k] = ta[DEN_W-1:0];
            na_in[k]    = {xa[NUM_W-2:0], 1'b0};
         end
         if (tb >= {1'b0, dn}) begin
            rem_b_in[k] = db[DEN_W-1:0];
            nb_in[k]    = {xb[NUM_W-2:0], 1'b1};
         end else begin
            rem_b_in[k] = tb[DEN_W-1:0];
            nb_in[k]    = {xb[NUM_W-2:0], 1'b0};
         end
         den_in[k]  = dn;
         side_in[k] = sd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NUM_W-2:0], in_valid};
      end
      if (en) begin
         for (int k = 0; k < NUM_W; k++) begin
            rem_a_ff[k] <= rem_a_in[k];
            rem_b_ff[k] <= rem_b_in[k];
            na_ff[k]    <= na_in[k];
            nb_ff[k]    <= nb_in[k];
            den_ff[k]   <= den_in[k];
            side_ff[k]  <= side_in[k];
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quo_a = na_ff[NUM_W-1];
   assign out_quo_b = nb_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];
endmodule
`default_nettype wire

// ===== sv/qrs_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt
   import qrs_pkg::*;
#(
   parameter int OP_W   = 2 * QRS_COEF_W,
   parameter int SIDE_W = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [OP_W-1:0]     in_op,
   input  wire logic [SIDE_W-1:0]   in_side,
   output logic                     out_valid,
   output logic [OP_W/2-1:0]        out_root,
   output logic [SIDE_W-1:0]        out_side
);
   localparam int ROOT_W = OP_W / 2;
   localparam int REM_W  = ROOT_W + 1;

   logic [ROOT_W-1:0] vld_ff;
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic [OP_W-1:0]   op_ff   [ROOT_W];
   logic [OP_W-1:0]   op_in   [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];
   logic [SIDE_W-1:0] side_in [ROOT_W];

   // rem = 4*rem + next pair; subtract 4*root+1 when it fits
   always_comb begin
      logic [REM_W-1:0]  rm;
      logic [ROOT_W-1:0] rt;
      logic [OP_W-1:0]   op;
      logic [SIDE_W-1:0] sd;
      logic [REM_W+1:0]  cur, trial, diff;
      for (int k = 0; k < ROOT_W; k++) begin
         if (k == 0) begin
            rm = '0;
            rt = '0;
            op = in_op;
            sd = in_side;
         end else begin
            rm = rem_ff[k-1];
            rt = root_ff[k-1];
            op = op_ff[k-1];
            sd = side_ff[k-1];
         end
         cur   = {rm, op[OP_W-1 -: 2]};
         trial = {1'b0, rt, 2'b01};
         diff  = cur - trial;
         if (cur >= trial) begin
            rem_in[k]  = diff[REM_W-1:0];
            root_in[k] = {rt[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = cur[REM_W-1:0];
            root_in[k] = {rt[ROOT_W-2:0], 1'b0};
         end
         op_in[k]   = {op[OP_W-3:0], 2'b00};
         side_in[k] = sd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ROOT_W-2:0], in_valid};
      end
      if (en) begin
         for (int k = 0; k < ROOT_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            op_ff[k]   <= op_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];
endmodule
`default_nettype wire
